### hw/rtl/timestamped_velocity_ledger_core_macros.svh
// assertion helpers for the ledger datapath rtl
`ifndef TIMESTAMPED_VELOCITY_LEDGER_CORE_MACROS_SVH
`define TIMESTAMPED_VELOCITY_LEDGER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// condition that must hold at every clock edge out of reset
`define TVL_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tvl invariant violated");
// consequence that must hold in the cycle after the trigger
`define TVL_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("tvl sequence violated");
`else
`define TVL_ASSERT_ALWAYS(label, cond)
`define TVL_ASSERT_NEXT(label, trig, cons)
`endif

`endif

### hw/rtl/tvl_pkg.sv
package tvl_pkg;

    localparam int TVL_CAPACITY = 256;

    localparam int TIME_W  = 40;
    localparam int VEL_W   = 24;
    localparam int CONF_W  = 17;
    localparam int AREA_W  = 48;
    localparam int EPOCH_W = 32;
    localparam int STAT_W  = 4;
    localparam int DT_HALF = 20;
    localparam int MUL_W   = VEL_W + DT_HALF + 1;
    localparam int PROD_W  = 64;
    localparam int SHIFT   = 12;

    localparam logic [CONF_W-1:0] CONF_ONE = 17'd65536;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_INTEG  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_VALID      = 4'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 4'd1;
    localparam logic [STAT_W-1:0] ST_BAD_REQ    = 4'd2;
    localparam logic [STAT_W-1:0] ST_INCOMPLETE = 4'd3;
    localparam logic [STAT_W-1:0] ST_BAD_MODEL  = 4'd4;
    localparam logic [STAT_W-1:0] ST_BAD_SAMPLE = 4'd5;
    localparam logic [STAT_W-1:0] ST_BACKEND    = 4'd6;
    localparam logic [STAT_W-1:0] ST_CLOCK      = 4'd7;
    localparam logic [STAT_W-1:0] ST_EPOCH      = 4'd8;

    localparam logic signed [PROD_W-1:0] SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [PROD_W-1:0] SAT_LO = -64'sh0000_8000_0000_0000;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CLEAR, OP_AP_REJECT, OP_AP_EPOCH, OP_AP_WRITE,
        OP_RD_OLDEST, OP_SR_INIT, OP_SR_READ, OP_SR_STEP, OP_SR_SAVE,
        OP_AREA_READ, OP_AREA_DT, OP_AREA_MLO, OP_AREA_MHI, OP_AREA_SUM,
        OP_AREA_SAVE, OP_SC_INIT, OP_SC_READ, OP_SC_STEP, OP_FINISH
    } op_t;

    // search pass and area source share one selector
    typedef enum logic [1:0] {SEL_B_LE, SEL_E_LE, SEL_E_LT, SEL_PREV} sel_t;

    typedef enum logic [2:0] {
        RK_CLEAR, RK_BADREQ, RK_LATCHED, RK_ACCEPT,
        RK_ZERO_WIN, RK_INCOMPLETE, RK_BADMODEL, RK_WINDOW
    } kind_t;

    typedef struct packed {
        op_t   op;
        sel_t  sel;
        kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] item_cmd;
        logic       ap_reject;
        logic       ap_need_prev;
        logic       rev;
        logic       empty;
        logic       zero;
        logic       cover_fail;
        logic       sr_done;
        logic       sc_done;
        logic       bad;
        logic       out_free;
    } dp_stat_t;

    typedef struct packed {
        logic [TIME_W-1:0]        stamp;
        logic signed [VEL_W-1:0]  vel_x;
        logic signed [VEL_W-1:0]  vel_y;
        logic [CONF_W-1:0]        conf;
        logic                     model_ok;
        logic signed [AREA_W-1:0] area_x;
        logic signed [AREA_W-1:0] area_y;
    } entry_t;

    function automatic logic signed [AREA_W-1:0] sat48(input logic signed [PROD_W-1:0] v);
        logic signed [AREA_W-1:0] r;
        if (v > SAT_HI) r = SAT_HI[AREA_W-1:0];
        else if (v < SAT_LO) r = SAT_LO[AREA_W-1:0];
        else r = v[AREA_W-1:0];
        return r;
    endfunction

endpackage

### hw/rtl/timestamped_velocity_ledger_core.sv
// timestamped velocity ledger: one result per item, one item in flight at a time
// append: decode, then extend the previous sample's area when needed, then write
// integrate: three binary searches, two area evaluations and a confidence scan
//   over the covered samples, all on the ring's one read port
// a finished result waits in an output register while the next item is taken
// async active-low reset empties the ring and latches the empty status; no clearing pass
module timestamped_velocity_ledger_core #(
    parameter int CAPACITY = tvl_pkg::TVL_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        cmd,
    input  logic [tvl_pkg::TIME_W-1:0]        first_time,
    input  logic [tvl_pkg::TIME_W-1:0]        second_time,
    input  logic signed [tvl_pkg::VEL_W-1:0]  vel_x,
    input  logic signed [tvl_pkg::VEL_W-1:0]  vel_y,
    input  logic [tvl_pkg::EPOCH_W-1:0]       epoch,
    input  logic                              delivered,
    input  logic                              emit_enabled,
    input  logic                              model_ok,
    input  logic [tvl_pkg::CONF_W-1:0]        confidence,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              accepted,
    output logic [tvl_pkg::STAT_W-1:0]        status,
    output logic                              window_ok,
    output logic signed [tvl_pkg::AREA_W-1:0] disp_x,
    output logic signed [tvl_pkg::AREA_W-1:0] disp_y,
    output logic [tvl_pkg::CONF_W-1:0]        min_confidence,
    output logic                              confidence_found
);
    import tvl_pkg::*;

    // command from the sequencer, flags back from the datapath
    dp_cmd_t  ctl;
    dp_stat_t sts;

    // sequencer: decode, append write, and for integrate three binary searches, two area evaluations, scan
    tvl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .ctl      (ctl),
        .sts      (sts)
    );

    // ring memory, ring pointers, split multiplier and result register
    tvl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .sts              (sts),
        .cmd              (cmd),
        .first_time       (first_time),
        .second_time      (second_time),
        .vel_x            (vel_x),
        .vel_y            (vel_y),
        .epoch            (epoch),
        .delivered        (delivered),
        .emit_enabled     (emit_enabled),
        .model_ok         (model_ok),
        .confidence       (confidence),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .accepted         (accepted),
        .status           (status),
        .window_ok        (window_ok),
        .disp_x           (disp_x),
        .disp_y           (disp_y),
        .min_confidence   (min_confidence),
        .confidence_found (confidence_found)
    );

endmodule

### hw/rtl/tvl_ctrl.sv
module tvl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output tvl_pkg::dp_cmd_t  ctl,
    input  tvl_pkg::dp_stat_t sts
);
    import tvl_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE    = 17'b00000000000000001,
        S_DECODE  = 17'b00000000000000010,
        S_OLD_CHK = 17'b00000000000000100,
        S_SR_INIT = 17'b00000000000001000,
        S_SR_TEST = 17'b00000000000010000,
        S_SR_CMP  = 17'b00000000000100000,
        S_AR_RD   = 17'b00000000001000000,
        S_AR_DT   = 17'b00000000010000000,
        S_AR_MLO  = 17'b00000000100000000,
        S_AR_MHI  = 17'b00000001000000000,
        S_AR_SUM  = 17'b00000010000000000,
        S_AR_SAVE = 17'b00000100000000000,
        S_SC_INIT = 17'b00001000000000000,
        S_SC_TEST = 17'b00010000000000000,
        S_SC_CHK  = 17'b00100000000000000,
        S_AP_WR   = 17'b01000000000000000,
        S_FIN     = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;
    sel_t   sel_reg, sel_next;
    kind_t  kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= SEL_B_LE;
            kind_reg  <= RK_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        kind_next  = kind_reg;
        in_ready   = 1'b0;
        ctl.op     = OP_NONE;
        ctl.sel    = sel_reg;
        ctl.kind   = kind_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FIN;
                unique case (sts.item_cmd)
                    CMD_APPEND:
                    begin
                        if (sts.ap_reject)
                        begin
                            ctl.op    = OP_AP_REJECT;
                            kind_next = RK_LATCHED;
                        end
                        else
                        begin
                            ctl.op = OP_AP_EPOCH;
                            if (sts.ap_need_prev)
                            begin
                                sel_next   = SEL_PREV;
                                state_next = S_AR_RD;
                            end
                            else
                            begin
                                state_next = S_AP_WR;
                            end
                        end
                    end
                    CMD_INTEG:
                    begin
                        if (sts.rev) kind_next = RK_BADREQ;
                        else if (sts.empty) kind_next = RK_LATCHED;
                        else if (sts.zero) kind_next = RK_ZERO_WIN;
                        else
                        begin
                            ctl.op     = OP_RD_OLDEST;
                            state_next = S_OLD_CHK;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        ctl.op    = OP_CLEAR;
                        kind_next = RK_CLEAR;
                    end
                    default: kind_next = RK_BADREQ;
                endcase
            end
            S_OLD_CHK:
            begin
                if (sts.cover_fail)
                begin
                    kind_next  = RK_INCOMPLETE;
                    state_next = S_FIN;
                end
                else
                begin
                    sel_next   = SEL_B_LE;
                    state_next = S_SR_INIT;
                end
            end
            S_SR_INIT:
            begin
                ctl.op     = OP_SR_INIT;
                state_next = S_SR_TEST;
            end
            S_SR_TEST:
            begin
                if (sts.sr_done)
                begin
                    ctl.op = OP_SR_SAVE;
                    unique case (sel_reg)
                        SEL_B_LE:
                        begin
                            sel_next   = SEL_E_LE;
                            state_next = S_SR_INIT;
                        end
                        SEL_E_LE:
                        begin
                            sel_next   = SEL_E_LT;
                            state_next = S_SR_INIT;
                        end
                        default:
                        begin
                            sel_next   = SEL_B_LE;
                            state_next = S_AR_RD;
                        end
                    endcase
                end
                else
                begin
                    ctl.op     = OP_SR_READ;
                    state_next = S_SR_CMP;
                end
            end
            S_SR_CMP:
            begin
                ctl.op     = OP_SR_STEP;
                state_next = S_SR_TEST;
            end
            S_AR_RD:
            begin
                ctl.op     = OP_AREA_READ;
                state_next = S_AR_DT;
            end
            S_AR_DT:
            begin
                ctl.op     = OP_AREA_DT;
                state_next = S_AR_MLO;
            end
            S_AR_MLO:
            begin
                ctl.op     = OP_AREA_MLO;
                state_next = S_AR_MHI;
            end
            S_AR_MHI:
            begin
                ctl.op     = OP_AREA_MHI;
                state_next = S_AR_SUM;
            end
            S_AR_SUM:
            begin
                ctl.op     = OP_AREA_SUM;
                state_next = S_AR_SAVE;
            end
            S_AR_SAVE:
            begin
                ctl.op = OP_AREA_SAVE;
                unique case (sel_reg)
                    SEL_PREV: state_next = S_AP_WR;
                    SEL_B_LE:
                    begin
                        sel_next   = SEL_E_LE;
                        state_next = S_AR_RD;
                    end
                    default: state_next = S_SC_INIT;
                endcase
            end
            S_SC_INIT:
            begin
                ctl.op     = OP_SC_INIT;
                state_next = S_SC_TEST;
            end
            S_SC_TEST:
            begin
                if (sts.sc_done)
                begin
                    kind_next  = sts.bad ? RK_BADMODEL : RK_WINDOW;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.op     = OP_SC_READ;
                    state_next = S_SC_CHK;
                end
            end
            S_SC_CHK:
            begin
                ctl.op     = OP_SC_STEP;
                state_next = S_SC_TEST;
            end
            S_AP_WR:
            begin
                ctl.op     = OP_AP_WRITE;
                kind_next  = RK_ACCEPT;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    ctl.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### hw/rtl/tvl_dp.sv
`include "timestamped_velocity_ledger_core_macros.svh"

module tvl_dp #(
    parameter int CAPACITY = tvl_pkg::TVL_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tvl_pkg::dp_cmd_t                  ctl,
    output tvl_pkg::dp_stat_t                 sts,
    input  logic [1:0]                        cmd,
    input  logic [tvl_pkg::TIME_W-1:0]        first_time,
    input  logic [tvl_pkg::TIME_W-1:0]        second_time,
    input  logic signed [tvl_pkg::VEL_W-1:0]  vel_x,
    input  logic signed [tvl_pkg::VEL_W-1:0]  vel_y,
    input  logic [tvl_pkg::EPOCH_W-1:0]       epoch,
    input  logic                              delivered,
    input  logic                              emit_enabled,
    input  logic                              model_ok,
    input  logic [tvl_pkg::CONF_W-1:0]        confidence,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              accepted,
    output logic [tvl_pkg::STAT_W-1:0]        status,
    output logic                              window_ok,
    output logic signed [tvl_pkg::AREA_W-1:0] disp_x,
    output logic signed [tvl_pkg::AREA_W-1:0] disp_y,
    output logic [tvl_pkg::CONF_W-1:0]        min_confidence,
    output logic                              confidence_found
);
    import tvl_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // latched item
    logic [1:0]               icmd_reg;
    logic [TIME_W-1:0]        b_reg, e_reg;
    logic signed [VEL_W-1:0]  ivx_reg, ivy_reg;
    logic [EPOCH_W-1:0]       ep_reg;
    logic                     deliv_reg, en_reg, mok_reg;
    logic [CONF_W-1:0]        conf_reg;

    // ring state
    logic [IW-1:0]            head_reg;
    logic [CW-1:0]            count_reg;
    logic [TIME_W-1:0]        last_reg, cov_reg;
    logic [EPOCH_W-1:0]       dev_reg;
    logic [STAT_W-1:0]        lat_reg;

    entry_t                   ring_mem [CAPACITY];
    entry_t                   rd_reg;

    logic [CW-1:0]            lo_reg, hi_reg, mid_reg;
    logic [CW-1:0]            sb_reg, sle_reg, slt_reg, i_reg;
    logic [TIME_W-1:0]        dt_reg;
    logic signed [MUL_W-1:0]  plo_x_reg, plo_y_reg, phi_x_reg, phi_y_reg;
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic signed [AREA_W-1:0] bx_reg, by_reg, ex_reg, ey_reg;
    logic [CONF_W-1:0]        minc_reg;
    logic                     found_reg, bad_reg;

    logic                     out_valid_reg, acc_reg, wok_reg, cfound_reg;
    logic [STAT_W-1:0]        status_reg;
    logic signed [AREA_W-1:0] dx_reg, dy_reg;
    logic [CONF_W-1:0]        mconf_reg;

    logic f6, f5, drop, chg, clk_fail, go;
    logic [CW-1:0]            mid, area_idx;
    logic [TIME_W-1:0]        srch_t, area_t;
    logic [IW-1:0]            raddr;
    logic                     mem_re;
    logic [STAT_W-1:0]        reason;

    function automatic logic [IW-1:0] phys(input logic [CW-1:0] x);
        logic [CW:0] s;
        s = (CW+1)'(head_reg) + (CW+1)'(x);
        if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
        return s[IW-1:0];
    endfunction

    // append decision
    assign f6       = !deliv_reg || !en_reg;
    assign f5       = (b_reg == '0) || (ep_reg == '0);
    assign drop     = ((lat_reg == ST_BAD_SAMPLE) || (lat_reg == ST_BACKEND)
                      || (lat_reg == ST_CLOCK)) && (dev_reg != '0) && (ep_reg == dev_reg);
    assign chg      = (dev_reg != '0) && (ep_reg != dev_reg);
    assign clk_fail = !chg && (last_reg != '0) && (b_reg <= last_reg);
    assign reason   = f6 ? ST_BACKEND : (f5 ? ST_BAD_SAMPLE : ST_CLOCK);

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign srch_t = (ctl.sel == SEL_B_LE) ? b_reg : e_reg;
    assign go     = (ctl.sel == SEL_E_LT) ? (rd_reg.stamp < srch_t)
                                          : (rd_reg.stamp <= srch_t);
    assign area_t = (ctl.sel == SEL_E_LE) ? e_reg : b_reg;

    always_comb
    begin
        case (ctl.sel)
            SEL_E_LE: area_idx = sle_reg - CW'(1);
            SEL_PREV: area_idx = count_reg - CW'(1);
            default:  area_idx = sb_reg - CW'(1);
        endcase
    end

    always_comb
    begin
        mem_re = 1'b1;
        case (ctl.op)
            OP_RD_OLDEST: raddr = head_reg;
            OP_SR_READ:   raddr = phys(mid);
            OP_AREA_READ: raddr = phys(area_idx);
            OP_SC_READ:   raddr = phys(i_reg);
            default:
            begin
                raddr  = head_reg;
                mem_re = 1'b0;
            end
        endcase
    end

    assign sts.item_cmd     = icmd_reg;
    assign sts.ap_reject    = f6 || f5 || drop || clk_fail;
    assign sts.ap_need_prev = !chg && (count_reg != '0);
    assign sts.rev          = e_reg < b_reg;
    assign sts.empty        = count_reg == '0;
    assign sts.zero         = b_reg == e_reg;
    assign sts.cover_fail   = (b_reg < cov_reg) || (b_reg < rd_reg.stamp)
                              || (e_reg <= rd_reg.stamp);
    assign sts.sr_done      = lo_reg == hi_reg;
    assign sts.sc_done      = (i_reg >= slt_reg) || (i_reg >= count_reg);
    assign sts.bad          = bad_reg;
    assign sts.out_free     = !out_valid_reg || out_ready;

    // sample store
    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_AP_WRITE)
        begin
            ring_mem[phys(count_reg)] <= '{
                stamp:    b_reg,
                vel_x:    ivx_reg,
                vel_y:    ivy_reg,
                conf:     conf_reg,
                model_ok: mok_reg,
                area_x:   (count_reg != '0) ? bx_reg : '0,
                area_y:   (count_reg != '0) ? by_reg : '0
            };
        end
        if (mem_re)
        begin
            rd_reg <= ring_mem[raddr];
        end
    end

    // item latch, search, area and scan payload
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_LOAD:
            begin
                icmd_reg  <= cmd;
                b_reg     <= first_time;
                e_reg     <= second_time;
                ivx_reg   <= vel_x;
                ivy_reg   <= vel_y;
                ep_reg    <= epoch;
                deliv_reg <= delivered;
                en_reg    <= emit_enabled;
                mok_reg   <= model_ok;
                conf_reg  <= confidence;
            end
            OP_SR_INIT:
            begin
                lo_reg <= '0;
                hi_reg <= count_reg;
            end
            OP_SR_READ: mid_reg <= mid;
            OP_SR_STEP:
            begin
                if (go) lo_reg <= mid_reg + CW'(1);
                else hi_reg <= mid_reg;
            end
            OP_SR_SAVE:
            begin
                case (ctl.sel)
                    SEL_B_LE: sb_reg <= lo_reg;
                    SEL_E_LE: sle_reg <= lo_reg;
                    default:  slt_reg <= lo_reg;
                endcase
            end
            OP_AREA_DT:
                dt_reg <= (area_t >= rd_reg.stamp) ? (area_t - rd_reg.stamp) : '0;
            OP_AREA_MLO:
            begin
                plo_x_reg <= MUL_W'(rd_reg.vel_x)
                             * MUL_W'(signed'({1'b0, dt_reg[DT_HALF-1:0]}));
                plo_y_reg <= MUL_W'(rd_reg.vel_y)
                             * MUL_W'(signed'({1'b0, dt_reg[DT_HALF-1:0]}));
            end
            OP_AREA_MHI:
            begin
                phi_x_reg <= MUL_W'(rd_reg.vel_x)
                             * MUL_W'(signed'({1'b0, dt_reg[TIME_W-1:DT_HALF]}));
                phi_y_reg <= MUL_W'(rd_reg.vel_y)
                             * MUL_W'(signed'({1'b0, dt_reg[TIME_W-1:DT_HALF]}));
            end
            OP_AREA_SUM:
            begin
                prod_x_reg <= PROD_W'(plo_x_reg) + (PROD_W'(phi_x_reg) <<< DT_HALF);
                prod_y_reg <= PROD_W'(plo_y_reg) + (PROD_W'(phi_y_reg) <<< DT_HALF);
            end
            OP_AREA_SAVE:
            begin
                // floor shift of the product, then add onto the stored prefix
                if (ctl.sel == SEL_E_LE)
                begin
                    ex_reg <= sat48(PROD_W'(rd_reg.area_x) + (prod_x_reg >>> SHIFT));
                    ey_reg <= sat48(PROD_W'(rd_reg.area_y) + (prod_y_reg >>> SHIFT));
                end
                else
                begin
                    bx_reg <= sat48(PROD_W'(rd_reg.area_x) + (prod_x_reg >>> SHIFT));
                    by_reg <= sat48(PROD_W'(rd_reg.area_y) + (prod_y_reg >>> SHIFT));
                end
            end
            OP_SC_INIT:
            begin
                i_reg     <= sb_reg - CW'(1);
                minc_reg  <= CONF_ONE;
                found_reg <= 1'b0;
                bad_reg   <= 1'b0;
            end
            OP_SC_STEP:
            begin
                i_reg <= i_reg + CW'(1);
                if (!rd_reg.model_ok || (rd_reg.conf > CONF_ONE)) bad_reg <= 1'b1;
                else
                begin
                    found_reg <= 1'b1;
                    if (rd_reg.conf < minc_reg) minc_reg <= rd_reg.conf;
                end
            end
            default: ;
        endcase
    end

    // ring control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            last_reg  <= '0;
            cov_reg   <= '0;
            dev_reg   <= '0;
            lat_reg   <= ST_EMPTY;
        end
        else
        begin
            case (ctl.op)
                OP_CLEAR:
                begin
                    head_reg  <= '0;
                    count_reg <= '0;
                    last_reg  <= '0;
                    cov_reg   <= '0;
                    dev_reg   <= '0;
                    lat_reg   <= ST_EMPTY;
                end
                OP_AP_REJECT:
                begin
                    // same-epoch drop after a failure leaves everything alone
                    if (f6 || f5 || !drop)
                    begin
                        head_reg  <= '0;
                        count_reg <= '0;
                        last_reg  <= '0;
                        cov_reg   <= '0;
                        lat_reg   <= reason;
                        if ((ep_reg != '0) && ((dev_reg == '0) || (ep_reg == dev_reg)))
                            dev_reg <= ep_reg;
                    end
                end
                OP_AP_EPOCH:
                begin
                    if (chg)
                    begin
                        head_reg  <= '0;
                        count_reg <= '0;
                        last_reg  <= '0;
                        cov_reg   <= '0;
                        lat_reg   <= ST_EPOCH;
                        dev_reg   <= ep_reg;
                    end
                    else if (dev_reg == '0)
                    begin
                        dev_reg <= ep_reg;
                    end
                end
                OP_AP_WRITE:
                begin
                    if (count_reg < CW'(CAPACITY)) count_reg <= count_reg + CW'(1);
                    else head_reg <= (head_reg == IW'(CAPACITY - 1)) ? '0 : head_reg + IW'(1);
                    if (count_reg == '0) cov_reg <= b_reg;
                    last_reg <= b_reg;
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else if (ctl.op == OP_FINISH) out_valid_reg <= 1'b1;
        else if (out_ready) out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_FINISH)
        begin
            acc_reg    <= ctl.kind == RK_ACCEPT;
            wok_reg    <= (ctl.kind == RK_ZERO_WIN) || (ctl.kind == RK_WINDOW);
            dx_reg     <= '0;
            dy_reg     <= '0;
            mconf_reg  <= '0;
            cfound_reg <= 1'b0;
            case (ctl.kind)
                RK_CLEAR:      status_reg <= ST_EMPTY;
                RK_BADREQ:     status_reg <= ST_BAD_REQ;
                RK_LATCHED:    status_reg <= lat_reg;
                RK_INCOMPLETE: status_reg <= ST_INCOMPLETE;
                RK_BADMODEL:   status_reg <= ST_BAD_MODEL;
                default:       status_reg <= ST_VALID;
            endcase
            if (ctl.kind == RK_WINDOW)
            begin
                dx_reg     <= sat48(PROD_W'(ex_reg) - PROD_W'(bx_reg));
                dy_reg     <= sat48(PROD_W'(ey_reg) - PROD_W'(by_reg));
                mconf_reg  <= found_reg ? minc_reg : '0;
                cfound_reg <= found_reg;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = acc_reg;
    assign status           = status_reg;
    assign window_ok        = wok_reg;
    assign disp_x           = dx_reg;
    assign disp_y           = dy_reg;
    assign min_confidence   = mconf_reg;
    assign confidence_found = cfound_reg;

    `TVL_ASSERT_ALWAYS(a_count_cap, count_reg <= CW'(CAPACITY))
    `TVL_ASSERT_ALWAYS(a_head_range, head_reg <= IW'(CAPACITY - 1))
    `TVL_ASSERT_ALWAYS(a_search_order, (ctl.op != OP_SR_STEP) || (lo_reg <= hi_reg))
    `TVL_ASSERT_ALWAYS(a_finish_free, !((ctl.op == OP_FINISH) && out_valid_reg && !out_ready))
    `TVL_ASSERT_NEXT(a_finish_shows, ctl.op == OP_FINISH, out_valid_reg)

endmodule
